// ===== hw/rtl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared constants for the scanline timing controller: line geometry, field
// widths and configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lsc_pkg;

    localparam int VISIBLE_LINES = 160;
    localparam int HBLANK_BEGIN  = 960;
    localparam int HBLANK_LENGTH = 272;
    localparam int TOTAL_LINES   = 228;
    localparam int HBLANK_DELAY  = 46;

    localparam int CYC_W   = 11;
    localparam int LINE_W  = 8;
    localparam int ELAP_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam int LINE_END_CYC  = HBLANK_BEGIN + HBLANK_LENGTH;
    localparam int HBLANK_AT_CYC = HBLANK_BEGIN + HBLANK_DELAY;

    localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_IRQ_EN  = 2'd1;

endpackage

// ===== hw/rtl/lcd_scanline_timing_controller.sv =====
// ----------------------------------------------------------------------------
// lcd_scanline_timing_controller
// Line and frame timing with status flags and one-shot interrupt requests.
// ----------------------------------------------------------------------------
// Each input word carries the elapsed CPU time since the last update. The
// word is accepted on any cycle in which the result register is empty or
// being drained, and its status word appears in the result register on the
// next cycle, so one word per clock is sustained while the output is drained.
// The rate is set by the single add-and-compare step between the timing state
// registers and the result register. Configuration writes are taken at once.
`timescale 1ns / 1ps

module lcd_scanline_timing_controller
    import lsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ELAP_W-1:0]     i_elapsed_cycles,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [LINE_W-1:0]     o_scanline,
    output logic                  o_hblank_flag,
    output logic                  o_vblank_flag,
    output logic                  o_vcount_match,
    output logic                  o_hblank_irq,
    output logic                  o_vblank_irq,
    output logic                  o_line_match_irq,
    output logic                  o_render_line
);

    typedef enum logic [1:0] {
        PH_VISIBLE = 2'd0,
        PH_HBLANK  = 2'd1,
        PH_VBLANK  = 2'd2,
        PH_SPARE   = 2'd3
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [CYC_W-1:0]    r_cycles, n_cycles;
    logic [LINE_W-1:0]   r_line, n_line;
    logic                r_hblank, n_hblank;
    logic                r_vblank, n_vblank;
    logic                r_match, n_match;
    logic [LINE_W-1:0]   r_target;
    logic                r_irq_en;

    logic                r_out_valid;
    logic [LINE_W-1:0]   r_scanline;
    logic                r_hblank_flag, r_vblank_flag, r_vcount_match;
    logic                r_hblank_irq, r_vblank_irq, r_line_match_irq, r_render_line;
    logic                n_h_irq, n_v_irq, n_c_irq, n_render;

    logic [CYC_W:0]      sum;
    logic [CYC_W-1:0]    sat_cycles;
    logic [LINE_W-1:0]   inc_line;
    logic                line_end;
    logic                in_acc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;

    assign sum        = {1'b0, r_cycles} + {{(CYC_W + 1 - ELAP_W){1'b0}}, i_elapsed_cycles};
    assign sat_cycles = sum[CYC_W] ? {CYC_W{1'b1}} : sum[CYC_W-1:0];
    assign line_end   = sat_cycles >= CYC_W'(LINE_END_CYC);
    assign inc_line   = r_line + LINE_W'(1);

    always_comb begin
        n_phase  = r_phase;
        n_cycles = sat_cycles;
        n_line   = r_line;
        n_hblank = r_hblank;
        n_vblank = r_vblank;
        n_match  = r_match;
        n_h_irq  = 1'b0;
        n_v_irq  = 1'b0;
        n_c_irq  = 1'b0;
        n_render = 1'b0;
        unique case (r_phase)
            PH_HBLANK: begin
                if (line_end) begin
                    n_line   = inc_line;
                    n_hblank = 1'b0;
                    n_cycles = '0;
                    n_match  = (inc_line == r_target);
                    n_c_irq  = (inc_line == r_target) && r_irq_en;
                    if (inc_line == LINE_W'(VISIBLE_LINES)) begin
                        n_phase  = PH_VBLANK;
                        n_vblank = 1'b1;
                        n_v_irq  = 1'b1;
                    end else begin
                        n_phase = PH_VISIBLE;
                    end
                end
            end
            PH_VBLANK: begin
                if (line_end) begin
                    n_line   = inc_line;
                    n_hblank = 1'b0;
                    n_cycles = '0;
                    if (inc_line >= LINE_W'(TOTAL_LINES)) begin
                        n_line   = '0;
                        n_phase  = PH_VISIBLE;
                        n_vblank = 1'b0;
                    end
                    n_match = (n_line == r_target);
                    n_c_irq = (n_line == r_target) && r_irq_en;
                end
            end
            default: begin
                n_phase = PH_VISIBLE;
                if (sat_cycles >= CYC_W'(HBLANK_AT_CYC)) begin
                    n_render = (r_line < LINE_W'(VISIBLE_LINES));
                    n_phase  = PH_HBLANK;
                    n_hblank = 1'b1;
                    n_h_irq  = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_VISIBLE;
            r_cycles    <= '0;
            r_line      <= '0;
            r_hblank    <= 1'b0;
            r_vblank    <= 1'b0;
            r_match     <= 1'b0;
            r_target    <= '0;
            r_irq_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_VCOUNT_TARGET: r_target <= i_cfg_data[LINE_W-1:0];
                    CFG_MATCH_IRQ_EN:  r_irq_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_phase     <= n_phase;
                r_cycles    <= n_cycles;
                r_line      <= n_line;
                r_hblank    <= n_hblank;
                r_vblank    <= n_vblank;
                r_match     <= n_match;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_scanline       <= n_line;
            r_hblank_flag    <= n_hblank;
            r_vblank_flag    <= n_vblank;
            r_vcount_match   <= n_match;
            r_hblank_irq     <= n_h_irq;
            r_vblank_irq     <= n_v_irq;
            r_line_match_irq <= n_c_irq;
            r_render_line    <= n_render;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_scanline       = r_scanline;
    assign o_hblank_flag    = r_hblank_flag;
    assign o_vblank_flag    = r_vblank_flag;
    assign o_vcount_match   = r_vcount_match;
    assign o_hblank_irq     = r_hblank_irq;
    assign o_vblank_irq     = r_vblank_irq;
    assign o_line_match_irq = r_line_match_irq;
    assign o_render_line    = r_render_line;

endmodule

// ===== hw/rtl/lsc_checker.sv =====
// ----------------------------------------------------------------------------
// lsc_checker
// Port-level checks for the scanline timing controller, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lsc_checker
    import lsc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [LINE_W-1:0]     o_scanline,
    input logic                  o_hblank_flag,
    input logic                  o_vblank_flag,
    input logic                  o_vcount_match,
    input logic                  o_hblank_irq,
    input logic                  o_vblank_irq,
    input logic                  o_line_match_irq,
    input logic                  o_render_line
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_scanline)
            && $stable(o_hblank_flag) && $stable(o_vblank_flag)
            && $stable(o_vcount_match) && $stable(o_hblank_irq)
            && $stable(o_vblank_irq) && $stable(o_line_match_irq)
            && $stable(o_render_line))
        else $error("stalled result word changed");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_scanline < LINE_W'(TOTAL_LINES))
        else $error("scanline out of range");

    a_vblank_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_vblank_irq |-> o_vblank_flag
            && o_scanline == LINE_W'(VISIBLE_LINES) && !o_hblank_flag)
        else $error("vblank request without vblank entry");

    a_hblank_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hblank_irq |-> o_hblank_flag && !o_vblank_flag)
        else $error("hblank request outside visible frame");

    a_render: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_render_line |-> o_hblank_irq
            && o_scanline < LINE_W'(VISIBLE_LINES))
        else $error("render pulse without hblank entry");

endmodule

bind lcd_scanline_timing_controller lsc_checker u_lsc_checker (.*);
